### design/u8d_pkg.sv
package u8d_pkg;

    // Most results one input byte can cause: lead, two held continuations, current byte
    localparam int MAX_RES = 4;

    // Open-sequence length; zero means no sequence open
    localparam logic [2:0] EXP_IDLE  = 3'd0;
    localparam logic [2:0] EXP_TWO   = 3'd2;
    localparam logic [2:0] EXP_THREE = 3'd3;
    localparam logic [2:0] EXP_FOUR  = 3'd4;

    // Length reported on a single-byte result
    localparam logic [2:0] LEN_ONE = 3'd1;

    // One decoded result
    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  seq_length;
        logic        is_valid;
    } t_result;

    // All results caused by one input byte; slot 0 goes out first
    typedef struct packed {
        logic [2:0]                count;
        t_result [MAX_RES-1:0]     res;
    } t_bundle;

endpackage

### design/u8d_front.sv
module u8d_front
    import u8d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_q_full,
    output logic       o_push,
    output t_bundle    o_bundle
);

    logic       r_lead;
    logic [7:0] r_lead_byte;
    logic [2:0] r_exp;
    logic [1:0] r_rcv;
    logic [5:0] r_pay [2];

    logic [7:0] n_lead_byte;
    logic [2:0] n_exp;
    logic [1:0] n_rcv;

    logic       accept;
    logic       pay_we;
    t_result    idle_res;
    logic       idle_has;
    logic [2:0] idle_exp;
    logic [20:0] code;
    t_bundle    bundle;

    assign accept     = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;

    // Classify the byte as if no sequence were open
    always_comb begin
        idle_has            = 1'b1;
        idle_exp            = EXP_IDLE;
        idle_res.code_point = {13'd0, i_in_byte};
        idle_res.seq_length = LEN_ONE;
        idle_res.is_valid   = 1'b1;
        if (!i_in_byte[7]) begin
            idle_res.is_valid = 1'b1;
        end else if (i_in_byte[7:5] == 3'b110) begin
            idle_has = 1'b0;
            idle_exp = EXP_TWO;
        end else if (i_in_byte[7:4] == 4'b1110) begin
            idle_has = 1'b0;
            idle_exp = EXP_THREE;
        end else if (i_in_byte[7:3] == 5'b11110) begin
            idle_has = 1'b0;
            idle_exp = EXP_FOUR;
        end else begin
            idle_res.is_valid = 1'b0;
        end
    end

    // Assemble the code point on the final continuation
    always_comb begin
        unique case (r_exp)
            EXP_TWO:   code = {10'd0, r_lead_byte[4:0], i_in_byte[5:0]};
            EXP_THREE: code = {5'd0, r_lead_byte[3:0], r_pay[0], i_in_byte[5:0]};
            default:   code = {r_lead_byte[2:0], r_pay[0], r_pay[1], i_in_byte[5:0]};
        endcase
    end

    // Results for this byte and next sequence state
    always_comb begin
        bundle      = '0;
        n_lead_byte = r_lead_byte;
        n_exp       = r_exp;
        n_rcv       = r_rcv;
        pay_we      = 1'b0;
        if (r_exp == EXP_IDLE) begin
            bundle.count  = {2'b00, idle_has};
            bundle.res[0] = idle_res;
            if (!idle_has) begin
                n_lead_byte = i_in_byte;
                n_exp       = idle_exp;
                n_rcv       = 2'd0;
            end
        end else if (i_in_byte[7:6] == 2'b10) begin
            if (({1'b0, r_rcv} + 3'd2) >= r_exp) begin
                bundle.count                = 3'd1;
                bundle.res[0].code_point    = code;
                bundle.res[0].seq_length    = r_exp;
                bundle.res[0].is_valid      = 1'b1;
                n_exp                       = EXP_IDLE;
                n_rcv                       = 2'd0;
            end else begin
                pay_we = 1'b1;
                n_rcv  = r_rcv + 2'd1;
            end
        end else begin
            // Broken sequence: flush lead and held continuations as errors, then classify the byte afresh
            bundle.res[0].code_point = {13'd0, r_lead_byte};
            bundle.res[0].seq_length = LEN_ONE;
            bundle.res[0].is_valid   = 1'b0;
            bundle.res[1].code_point = {13'd0, 2'b10, r_pay[0]};
            bundle.res[1].seq_length = LEN_ONE;
            bundle.res[1].is_valid   = 1'b0;
            bundle.res[2].code_point = {13'd0, 2'b10, r_pay[1]};
            bundle.res[2].seq_length = LEN_ONE;
            bundle.res[2].is_valid   = 1'b0;
            bundle.res[r_rcv + 2'd1] = idle_res;
            bundle.count = 3'd1 + {1'b0, r_rcv} + {2'b00, idle_has};
            n_rcv        = 2'd0;
            if (idle_has) begin
                n_exp = EXP_IDLE;
            end else begin
                n_lead_byte = i_in_byte;
                n_exp       = idle_exp;
            end
        end
    end

    assign o_push   = accept && (bundle.count != 3'd0);
    assign o_bundle = bundle;

    // Sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_byte <= 8'd0;
            r_exp       <= EXP_IDLE;
            r_rcv       <= 2'd0;
        end else if (accept) begin
            r_lead_byte <= n_lead_byte;
            r_exp       <= n_exp;
            r_rcv       <= n_rcv;
        end
    end

    // Held continuation payloads
    always_ff @(posedge i_clk) begin
        if (accept && pay_we) begin
            r_pay[r_rcv[0]] <= i_in_byte[5:0];
        end
    end

    // Sequence open flag, used by checks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead <= 1'b0;
        end else if (accept) begin
            r_lead <= (n_exp != EXP_IDLE);
        end
    end

`ifndef SYNTH
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_bundle.count >= 3'd1 && o_bundle.count <= 3'd4))
        else $error("bundle count out of range");
    a_open_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lead == (r_exp != EXP_IDLE))
        else $error("open flag disagrees with expected length");
`endif

endmodule

### design/u8d_queue.sv
module u8d_queue
    import u8d_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_push_data,
    output logic    o_full,
    input  logic    i_pop,
    output t_bundle o_head,
    output logic    o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_bundle            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from empty queue");
`endif

endmodule

### design/u8d_back.sv
module u8d_back
    import u8d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_bundle     i_head,
    input  logic        i_empty,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [20:0] o_code_point,
    output logic [2:0]  o_seq_length,
    output logic        o_is_valid,
    output logic        o_last_of_run
);

    logic [1:0]  r_sub;
    logic        r_valid;
    logic [20:0] r_code_point;
    logic [2:0]  r_seq_length;
    logic        r_is_valid;
    logic        r_last;

    logic        load;
    logic        take;
    logic        is_last;
    t_result     cur;

    assign load    = !r_valid || !i_out_stall;
    assign take    = load && !i_empty;
    assign cur     = i_head.res[r_sub];
    assign is_last = ({1'b0, r_sub} == (i_head.count - 3'd1));
    assign o_pop   = take && is_last;

    // Walk the slots of the head bundle, one result per cycle while the output is not stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= 2'd0;
        end else if (take) begin
            r_sub <= is_last ? 2'd0 : r_sub + 2'd1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_code_point <= cur.code_point;
            r_seq_length <= cur.seq_length;
            r_is_valid   <= cur.is_valid;
            r_last       <= is_last;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_code_point  = r_code_point;
    assign o_seq_length  = r_seq_length;
    assign o_is_valid    = r_is_valid;
    assign o_last_of_run = r_last;

`ifndef SYNTH
    a_mid_bundle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sub != 2'd0) |-> !i_empty)
        else $error("slot walk active with no bundle queued");
`endif

endmodule

### design/utf8_stream_decoder.sv
// Channel   Valid         Stall         Payload
// input     i_in_valid    o_in_stall    i_in_byte
// output    o_out_valid   i_out_stall   o_code_point, o_seq_length, o_is_valid, o_last_of_run
//
// One byte accepted per cycle unless the queue is full; a result passes through the queue and
// the output register. A byte that breaks a sequence yields up to four results, sent one per
// cycle from the output stage unless it is stalled; the queue of QUEUE_DEPTH bundles absorbs
// them, input stalls when it fills. Synchronous active-low reset returns to idle with queue
// and output empty. Output is registered; input stall depends only on queue fill.
module utf8_stream_decoder
    import u8d_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [20:0] o_code_point,
    output logic [2:0]  o_seq_length,
    output logic        o_is_valid,
    output logic        o_last_of_run
);

    logic    q_full;
    logic    q_empty;
    logic    q_push;
    logic    q_pop;
    t_bundle push_bundle;
    t_bundle head_bundle;

    u8d_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_byte  (i_in_byte),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_bundle   (push_bundle)
    );

    u8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (push_bundle),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_head      (head_bundle),
        .o_empty     (q_empty)
    );

    u8d_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head_bundle),
        .i_empty       (q_empty),
        .o_pop         (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_code_point  (o_code_point),
        .o_seq_length  (o_seq_length),
        .o_is_valid    (o_is_valid),
        .o_last_of_run (o_last_of_run)
    );

endmodule

### tb/tb_utf8_stream_decoder.sv
module tb_utf8_stream_decoder
    import u8d_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // One expected decoder output
    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  seq_length;
        logic        is_valid;
        logic        last_of_run;
    } t_point;

    // Tracks decoder state and holds the code points still owed by the block
    class code_point_tracker;
        logic [7:0] lead_byte;
        logic [5:0] held_pay [2];
        logic [2:0] seq_total;
        logic [1:0] cont_count;
        t_point     pending_points [$];
        int         errors;

        function new();
            lead_byte   = 8'h00;
            held_pay[0] = 6'h00;
            held_pay[1] = 6'h00;
            seq_total   = EXP_IDLE;
            cont_count  = 2'd0;
            errors      = 0;
        endfunction

        function void push_point(logic [20:0] cp, logic [2:0] len, logic ok);
            t_point p;
            p.code_point  = cp;
            p.seq_length  = len;
            p.is_valid    = ok;
            p.last_of_run = 1'b0;
            pending_points.push_back(p);
        endfunction

        // Byte seen with no sequence open
        function void idle_byte(logic [7:0] b);
            if (!b[7]) begin
                push_point({13'd0, b}, LEN_ONE, 1'b1);
            end else begin
                if (b[7:5] == 3'b110) begin
                    seq_total = EXP_TWO;
                end else if (b[7:4] == 4'b1110) begin
                    seq_total = EXP_THREE;
                end else if (b[7:3] == 5'b11110) begin
                    seq_total = EXP_FOUR;
                end else begin
                    // stray continuation or 0xF8..0xFF
                    push_point({13'd0, b}, LEN_ONE, 1'b0);
                    return;
                end
                lead_byte  = b;
                cont_count = 2'd0;
            end
        endfunction

        // Accepted input request: work out every result it causes
        function void note_byte(logic [7:0] b);
            int          first_new;
            logic [20:0] code;
            first_new = pending_points.size();
            if (seq_total == EXP_IDLE) begin
                idle_byte(b);
            end else if (b[7:6] == 2'b10) begin
                if (int'(cont_count) + 2 >= int'(seq_total)) begin
                    case (seq_total)
                        EXP_TWO:   code = {16'd0, lead_byte[4:0]};
                        EXP_THREE: code = {17'd0, lead_byte[3:0]};
                        default:   code = {18'd0, lead_byte[2:0]};
                    endcase
                    for (int i = 0; i < int'(cont_count); i++)
                        code = (code << 6) | {15'd0, held_pay[i]};
                    code = (code << 6) | {15'd0, b[5:0]};
                    push_point(code, seq_total, 1'b1);
                    seq_total  = EXP_IDLE;
                    cont_count = 2'd0;
                end else begin
                    held_pay[cont_count[0]] = b[5:0];
                    cont_count = cont_count + 2'd1;
                end
            end else begin
                // broken sequence: lead, held continuations, then the byte afresh
                push_point({13'd0, lead_byte}, LEN_ONE, 1'b0);
                for (int i = 0; i < int'(cont_count); i++)
                    push_point({13'd0, 2'b10, held_pay[i]}, LEN_ONE, 1'b0);
                seq_total  = EXP_IDLE;
                cont_count = 2'd0;
                idle_byte(b);
            end
            if (pending_points.size() > first_new)
                pending_points[$].last_of_run = 1'b1;
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        // Compare one accepted output against the oldest pending point
        task check_result(logic [20:0] cp, logic [2:0] len, logic ok, logic last);
            t_point p;
            if (pending_points.size() == 0) begin
                report($sformatf("unexpected result cp=%h len=%0d", cp, len));
                return;
            end
            p = pending_points.pop_front();
            if (cp !== p.code_point)
                report($sformatf("code_point %h, want %h", cp, p.code_point));
            if (len !== p.seq_length)
                report($sformatf("seq_length %0d, want %0d", len, p.seq_length));
            if (ok !== p.is_valid)
                report($sformatf("is_valid %b, want %b", ok, p.is_valid));
            if (last !== p.last_of_run)
                report($sformatf("last_of_run %b, want %b", last, p.last_of_run));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_in_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [20:0] o_code_point;
    logic [2:0]  o_seq_length;
    logic        o_is_valid;
    logic        o_last_of_run;

    code_point_tracker tracker;
    bit                hold_req;
    int                burst_left;

    utf8_stream_decoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_byte     (i_in_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_code_point  (o_code_point),
        .o_seq_length  (o_seq_length),
        .o_is_valid    (o_is_valid),
        .o_last_of_run (o_last_of_run)
    );

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_byte   = 8'h00;
        i_out_stall = 1'b0;
        hold_req    = 1'b0;
        burst_left  = 0;
        tracker     = new();
    end

    always #5 i_clk = ~i_clk;

    // Monitor both channels at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                tracker.note_byte(i_in_byte);
            if (o_out_valid && !i_out_stall)
                tracker.check_result(o_code_point, o_seq_length, o_is_valid,
                                     o_last_of_run);
        end
    end

    // Offer one request, in bursts with random gaps
    task send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // One random group: mostly well-formed sequences, some broken, some noise
    task send_random_group(inout int sent);
        int         kind;
        int         len;
        int         keep;
        logic [7:0] r;
        kind = $urandom_range(0, 9);
        if (kind <= 7) begin
            len = (kind <= 5) ? $urandom_range(1, 4) : $urandom_range(2, 4);
            r = 8'($urandom);
            case (len)
                1:       r[7]   = 1'b0;
                2:       r[7:5] = 3'b110;
                3:       r[7:4] = 4'b1110;
                default: r[7:3] = 5'b11110;
            endcase
            send_byte(r);
            sent++;
            keep = (kind <= 5) ? len - 1 : $urandom_range(0, len - 2);
            repeat (keep) begin
                r = 8'($urandom);
                r[7:6] = 2'b10;
                send_byte(r);
                sent++;
            end
            if (kind > 5) begin
                // break the sequence with any non-continuation byte
                r = 8'($urandom);
                if (r[7:6] == 2'b10)
                    r[6] = 1'b1;
                send_byte(r);
                sent++;
            end
        end else begin
            r = 8'($urandom);
            send_byte(r);
            sent++;
        end
    endtask

    // Receiver stall pattern, with one long hold-off once random traffic runs
    initial begin
        int mode;
        int len;
        bit hold_done;
        hold_done = 1'b0;
        wait (i_rst_n);
        forever begin
            mode = $urandom_range(0, 2);
            len  = $urandom_range(5, 40);
            repeat (len) begin
                @(negedge i_clk);
                case (mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                    default: i_out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
            if (hold_req && !hold_done) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
                repeat (60) @(negedge i_clk);
                hold_done = 1'b1;
            end
        end
    end

    // Stimulus and end of run
    initial begin
        logic [7:0] directed [$];
        int         sent;
        directed = '{8'h00, 8'h7F, 8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC,
                     8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h80, 8'hBF, 8'hF8, 8'hFF,
                     8'hE2, 8'h41, 8'hF0, 8'h81, 8'h82, 8'h41,
                     8'hF0, 8'h90, 8'h80, 8'hC3, 8'hA9};
        sent = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, each length, strays, broken sequences
        foreach (directed[i])
            send_byte(directed[i]);

        hold_req = 1'b1;
        while (sent < 350)
            send_random_group(sent);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tracker.pending_points.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending_points.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
